// ===== sv/fba_pkg.sv =====
// Package with shared sizes and codes for the fit block allocator.
`timescale 1ns / 1ps

package fba_pkg;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;

   // Fixed field widths of the channels.
   localparam int LOAD_IDX_W  = 4;
   localparam int FIELD_W     = 16;
   localparam int POLICY_W    = 2;
   localparam int BLOCKS_W    = 5;
   localparam int CSR_DATA_W  = 5;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;

   typedef logic [POLICY_W-1:0] policy_type;
   localparam policy_type POLICY_FIRST = 2'd0;
   localparam policy_type POLICY_BEST  = 2'd1;
   localparam policy_type POLICY_WORST = 2'd2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   localparam logic CSR_FIT_POLICY    = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 5'd16;

endpackage

// ===== sv/fit_block_allocator.sv =====
// Fit block allocator: free-space table in a memory, scanned once per allocate request.
// A load gives no transaction. An allocate steps through accept, reads of the first N
// entries, drain and write-back, N = min(blocks_in_use, 16); with N zero the scan and
// drain are skipped. A waiting result holds the write-back. Requests are taken only
// in idle, one load per cycle, none during an allocate until its write-back is done.
// Reset: synchronous, active high; the table reads as all zero through valid bits.
`timescale 1ns / 1ps

module fit_block_allocator
   import fba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: load_index [3:0], load_size [19:4], request_size [35:20], zeros above.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: action.
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: granted [0], chosen_block [4:1], space_left [20:5], zeros above.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_WRITE} state_type;

   logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];

   state_type            state_ff, state_in;
   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   policy_type           policy_ff, policy_in;
   logic [BLOCKS_W-1:0]  blocks_ff, blocks_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pick_val_ff, pick_val_in;
   logic [SIZE_BITS-1:0] req_size_ff, req_size_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_addr;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;

   logic                 req_fire;
   logic [LOAD_IDX_W-1:0] f_load_index;
   logic [SIZE_BITS-1:0] f_load_size;
   logic [SIZE_BITS-1:0] f_request_size;
   logic [CNT_W-1:0]     count_now;
   logic [SIZE_BITS-1:0] cand;
   logic                 take;
   logic                 slot_free;
   logic [SIZE_BITS-1:0] left_val;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign f_load_index   = req_tdata[3:0];
   assign f_load_size    = SIZE_BITS'(req_tdata[19:4]);
   assign f_request_size = SIZE_BITS'(req_tdata[35:20]);

   // A search count above the table depth is clamped to the depth.
   assign count_now = (32'(blocks_ff) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                         : CNT_W'(blocks_ff);

   assign rd_addr = scan_idx_ff[IDX_W-1:0];

   // An entry never loaded since reset reads as zero.
   assign cand = rd_vld_ff ? rd_data_ff : '0;
   assign take = pend_ff && (cand >= req_size_ff) &&
                 (!found_ff ||
                  ((policy_ff == POLICY_BEST)  && (cand < pick_val_ff)) ||
                  ((policy_ff == POLICY_WORST) && (cand > pick_val_ff)));

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign left_val  = pick_val_ff - req_size_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      policy_in    = policy_ff;
      blocks_in    = blocks_ff;
      scan_idx_in  = scan_idx_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      pend_idx_in  = rd_addr;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_val_in  = pick_val_ff;
      req_size_in  = req_size_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = pick_ff;
      mem_wdata    = left_val;

      if (csr_we) begin
         case (csr_index)
            CSR_FIT_POLICY:    policy_in = csr_wdata[POLICY_W-1:0];
            CSR_BLOCKS_IN_USE: blocks_in = csr_wdata[BLOCKS_W-1:0];
            default:           ;
         endcase
      end

      if (take) begin
         found_in    = 1'b1;
         pick_in     = pend_idx_ff;
         pick_val_in = cand;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ACT_LOAD) begin
                  if (32'(f_load_index) < 32'(NUM_BLOCKS)) begin
                     mem_we    = 1'b1;
                     mem_waddr = IDX_W'(f_load_index);
                     mem_wdata = f_load_size;
                     valid_in[IDX_W'(f_load_index)] = 1'b1;
                  end
               end else begin
                  req_size_in = f_request_size;
                  found_in    = 1'b0;
                  pick_in     = '0;
                  pick_val_in = '0;
                  scan_idx_in = '0;
                  count_in    = count_now;
                  state_in    = (count_now == '0) ? ST_WRITE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            pend_in     = 1'b1;
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            if (scan_idx_ff + CNT_W'(1) == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  mem_we      = 1'b1;
                  rsp_data_in = RSP_DATA_W'({FIELD_W'(left_val),
                                             LOAD_IDX_W'(pick_ff), 1'b1});
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         policy_ff    <= POLICY_FIRST;
         blocks_ff    <= BLOCKS_RESET;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         policy_ff    <= policy_in;
         blocks_ff    <= blocks_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff <= scan_idx_in;
      count_ff    <= count_in;
      pend_idx_ff <= pend_idx_in;
      pick_ff     <= pick_in;
      pick_val_ff <= pick_val_in;
      req_size_ff <= req_size_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Free-space table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

`ifndef SYNTH
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result raised outside the write-back step");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !mem_we)
      else $error("table written during a scan");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && found_ff) |-> (pick_val_ff >= req_size_ff))
      else $error("chosen block cannot hold the request");
`endif

endmodule

// ===== tb/testbench.sv =====
// Testbench for the fit block allocator: free-space predictor, scoreboard and stream drivers.
`timescale 1ns / 1ps

module testbench;
   import fba_pkg::*;

   localparam policy_type POLICY_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT    = 800000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASES         = 10;
   localparam int PHASE_POLICY [PHASES] = '{POLICY_BEST, POLICY_WORST, POLICY_FIRST,
      POLICY_UNUSED, POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_BEST, POLICY_WORST,
      POLICY_FIRST};
   localparam int PHASE_BLOCKS [PHASES] = '{16, 16, 16, 16, 8, 1, 0, 31, 17, 2};
   localparam int PHASE_ITEMS  [PHASES] = '{300, 300, 250, 100, 200, 150, 60, 250, 200, 120};

   class alloc_scoreboard;
      typedef struct {
         logic                 granted;
         logic [IDX_W-1:0]     block;
         logic [SIZE_BITS-1:0] left;
      } grant_type;

      logic [SIZE_BITS-1:0] free_space [NUM_BLOCKS];
      policy_type           fit_policy;
      logic [BLOCKS_W-1:0]  blocks_in_use;
      grant_type            expected_grants [$];
      int                   failures;

      function new();
         foreach (free_space[i]) free_space[i] = '0;
         fit_policy    = POLICY_FIRST;
         blocks_in_use = BLOCKS_RESET;
         failures      = 0;
      endfunction

      function void write_register(logic index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_FIT_POLICY) begin
            fit_policy = value[POLICY_W-1:0];
         end else begin
            blocks_in_use = value[BLOCKS_W-1:0];
         end
      endfunction

      function int search_count();
         return (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use);
      endfunction

      // Loads update the table; allocates scan it and queue the grant they cause.
      function void note_request(logic action, logic [LOAD_IDX_W-1:0] index,
                                 logic [FIELD_W-1:0] size, logic [FIELD_W-1:0] request);
         grant_type g;
         int        pick;
         bit        found;
         int        n;
         if (action == ACT_LOAD) begin
            free_space[index] = size;
            return;
         end
         pick  = 0;
         found = 0;
         n     = search_count();
         for (int i = 0; i < n; i++) begin
            if (free_space[i] < request) continue;
            if (!found) begin
               found = 1;
               pick  = i;
               // First fit, and the unused code, stop at the lowest fitting entry.
               if (fit_policy != POLICY_BEST && fit_policy != POLICY_WORST) break;
            end else if (fit_policy == POLICY_BEST) begin
               if (free_space[i] < free_space[pick]) pick = i;
            end else if (fit_policy == POLICY_WORST) begin
               if (free_space[i] > free_space[pick]) pick = i;
            end
         end
         if (found) begin
            free_space[pick] = free_space[pick] - request;
            g.granted = 1'b1;
            g.block   = IDX_W'(pick);
            g.left    = free_space[pick];
         end else begin
            g.granted = 1'b0;
            g.block   = '0;
            g.left    = '0;
         end
         expected_grants.push_back(g);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         grant_type g;
         grant_type got;
         got.granted = data[0];
         got.block   = data[4:1];
         got.left    = data[20:5];
         if (expected_grants.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected transaction: granted=%0d block=%0d left=%0d",
                        got.granted, got.block, got.left);
            return;
         end
         g = expected_grants.pop_front();
         if (got.granted !== g.granted || got.block !== g.block || got.left !== g.left) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected granted=%0d block=%0d left=%0d, got %0d %0d %0d",
                        g.granted, g.block, g.left, got.granted, got.block, got.left);
         end
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   alloc_scoreboard sb = new();
   bit gaps_on     = 0;
   bit holdoff_req = 0;
   int burst_left  = 0;
   int cycle_count = 0;

   fit_block_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Result side: switches between always ready, coin flips and a rotating pattern,
   // and holds off for a long stretch when asked.
   initial begin : receiver
      int         mode;
      int         mode_left;
      int         held;
      logic [7:0] stall_pattern;
      mode          = 0;
      mode_left     = 0;
      stall_pattern = 8'b1011_0010;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_req) begin
            rsp_tready <= 1'b0;
            held = 0;
            while (held < HOLDOFF_CYCLES) begin
               @(posedge clock);
               held++;
            end
            holdoff_req = 0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: begin
                  rsp_tready <= stall_pattern[0];
                  stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
               end
            endcase
         end
      end
   end

   task automatic send_item(logic action, logic [LOAD_IDX_W-1:0] index,
                            logic [FIELD_W-1:0] size, logic [FIELD_W-1:0] request);
      int gap;
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0000, request, size, index};
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, index, size, request);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Loads give no transaction, so one may still be in flight once the queue is empty.
   task automatic set_registers(policy_type policy, logic [BLOCKS_W-1:0] blocks);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIT_POLICY;
      csr_wdata <= CSR_DATA_W'(policy);
      @(posedge clock);
      sb.write_register(CSR_FIT_POLICY, CSR_DATA_W'(policy));
      csr_index <= CSR_BLOCKS_IN_USE;
      csr_wdata <= blocks;
      @(posedge clock);
      sb.write_register(CSR_BLOCKS_IN_USE, blocks);
      csr_we <= 1'b0;
   endtask

   // Requests are mostly drawn from the current table so that grants, exact fits
   // and near misses all come up often.
   task automatic random_item();
      logic                  action;
      logic [LOAD_IDX_W-1:0] index;
      logic [FIELD_W-1:0]    size;
      logic [FIELD_W-1:0]    request;
      int                    roll;
      int                    n;
      int                    entry;
      action  = ($urandom_range(0, 99) < 40) ? ACT_LOAD : ACT_ALLOC;
      index   = LOAD_IDX_W'($urandom);
      size    = FIELD_W'($urandom);
      request = FIELD_W'($urandom);
      roll    = $urandom_range(0, 99);
      n       = sb.search_count();
      entry   = $urandom_range(0, (n == 0) ? NUM_BLOCKS - 1 : n - 1);
      if (action == ACT_LOAD) begin
         if (roll < 30) size = FIELD_W'($urandom_range(0, 255));
         else if (roll < 40) size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         else if (roll < 55) size = sb.free_space[$urandom_range(0, NUM_BLOCKS - 1)];
      end else begin
         if (roll < 10) request = '0;
         else if (roll < 20) request = sb.free_space[entry];
         else if (roll < 25) request = sb.free_space[entry] + 1'b1;
         else if (roll < 70) request = FIELD_W'($urandom_range(0, sb.free_space[entry]));
      end
      send_item(action, index, size, request);
   endtask

   initial begin : stimulus
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ACT_LOAD;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_FIT_POLICY;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, ties, every policy and search count corner.
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0000);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0001);
      send_item(ACT_LOAD, 4'd0, 16'hFFFF, 16'h0000);
      send_item(ACT_LOAD, 4'd15, 16'h8000, 16'hFFFF);
      send_item(ACT_LOAD, 4'd7, 16'h0001, 16'h0000);
      send_item(ACT_LOAD, 4'd3, 16'h8000, 16'h0000);
      send_item(ACT_ALLOC, 4'd15, 16'hFFFF, 16'hFFFF);
      set_registers(POLICY_BEST, 5'd16);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0001);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h8000);
      set_registers(POLICY_WORST, 5'd16);
      send_item(ACT_LOAD, 4'd0, 16'h0005, 16'h0000);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0002);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0000);
      set_registers(POLICY_UNUSED, 5'd16);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0000);
      set_registers(POLICY_FIRST, 5'd0);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0000);
      set_registers(POLICY_UNUSED, 5'd31);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h7FFE);
      set_registers(POLICY_FIRST, 5'd1);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0005);
      send_item(ACT_ALLOC, 4'd0, 16'h0000, 16'h0001);

      for (int p = 0; p < PHASES; p++) begin
         set_registers(policy_type'(PHASE_POLICY[p]), BLOCKS_W'(PHASE_BLOCKS[p]));
         gaps_on    = (p % 3 != 1);
         burst_left = 0;
         // Keep offering items while results back up behind a long hold-off.
         if (p == 1) holdoff_req = 1;
         for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
            if (p == 2 && k == PHASE_ITEMS[p] / 2) wait_drained();
            random_item();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.failures++;
         $display("%0d expected transactions never arrived", sb.pending());
      end
      if (sb.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fba_pkg.sv
sv/fit_block_allocator.sv
tb/testbench.sv
